// ===== hw/rtl/ps2_mouse_packet_tracker_macros.svh =====
// Assertion macros used by the checker of the mouse packet tracker.
`ifndef PS2_MOUSE_PACKET_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PS2MT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2 tracker check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PS2MT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2 tracker check failed");

`endif

// ===== hw/rtl/ps2mt_pkg.sv =====
`timescale 1ns / 1ps
package ps2mt_pkg;

   // default widths
   localparam int COORD_WIDTH_DEFAULT = 12;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // byte framing
   localparam int BYTE_WIDTH   = 8;
   localparam int BUTTON_WIDTH = 3;
   localparam logic [BYTE_WIDTH-1:0] HEADER_SYNC_MASK = 8'h08;
   localparam logic [BYTE_WIDTH-1:0] BUTTON_MASK      = 8'h07;

   // byte position codes within a three-byte packet
   localparam int POS_WIDTH = 2;
   localparam logic [POS_WIDTH-1:0] POS_HEADER = 2'd0;
   localparam logic [POS_WIDTH-1:0] POS_X      = 2'd1;
   localparam logic [POS_WIDTH-1:0] POS_Y      = 2'd2;

   // control registers
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 12;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPORTING_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COORD_MAX        = 2'd1;
   localparam logic [CSR_DATA_WIDTH-1:0]  COORD_MAX_RESET      = 12'd4095;

   // a framed packet as handed from the framer to the cursor logic
   typedef struct packed {
      logic                    complete;
      logic [BUTTON_WIDTH-1:0] buttons;
      logic [BYTE_WIDTH-1:0]   move_x;
      logic [BYTE_WIDTH-1:0]   move_y;
   } packet_type;

endpackage

// ===== hw/rtl/ps2mt_framer.sv =====
`timescale 1ns / 1ps
module ps2mt_framer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  byte_take,
   input  logic [ps2mt_pkg::BYTE_WIDTH-1:0]      data_byte,
   output logic                                  last_pending,
   output ps2mt_pkg::packet_type                 packet
);

   logic [ps2mt_pkg::POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [ps2mt_pkg::BYTE_WIDTH-1:0] header_ff, header_in;
   logic [ps2mt_pkg::BYTE_WIDTH-1:0] x_ff, x_in;
   logic                             complete;

   // next byte closes a packet (position 3 behaves as the last byte)
   assign last_pending = pos_ff[1];

   // position sequencing and byte latching
   always_comb begin
      pos_in    = pos_ff;
      header_in = header_ff;
      x_in      = x_ff;
      complete  = 1'b0;
      unique case (pos_ff)
         ps2mt_pkg::POS_HEADER: begin
            // drop bytes without the sync bit to regain framing
            if (byte_take && ((data_byte & ps2mt_pkg::HEADER_SYNC_MASK) != '0)) begin
               header_in = data_byte;
               pos_in    = ps2mt_pkg::POS_X;
            end
         end
         ps2mt_pkg::POS_X: begin
            if (byte_take) begin
               x_in   = data_byte;
               pos_in = ps2mt_pkg::POS_Y;
            end
         end
         default: begin
            if (byte_take) begin
               complete = 1'b1;
               pos_in   = ps2mt_pkg::POS_HEADER;
            end
         end
      endcase
   end

   assign packet.complete = complete;
   assign packet.buttons  = ps2mt_pkg::BUTTON_WIDTH'(header_ff & ps2mt_pkg::BUTTON_MASK);
   assign packet.move_x   = x_ff;
   assign packet.move_y   = data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= ps2mt_pkg::POS_HEADER;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // latched packet bytes, always written before use
   always_ff @(posedge clock) begin
      header_ff <= header_in;
      x_ff      <= x_in;
   end

endmodule

// ===== hw/rtl/ps2mt_cursor.sv =====
`timescale 1ns / 1ps
module ps2mt_cursor #(
   parameter int COORD_WIDTH = ps2mt_pkg::COORD_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = ps2mt_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ps2mt_pkg::packet_type  packet,
   input  logic [COORD_WIDTH-1:0] coord_max,
   output logic [COORD_WIDTH-1:0] cursor_x_next,
   output logic [COORD_WIDTH-1:0] cursor_y_next,
   output logic [COUNT_WIDTH-1:0] count_next
);

   // two spare bits: one for the carry past the top, one for sign
   localparam int SW = COORD_WIDTH + 2;
   localparam int PAD = SW - ps2mt_pkg::BYTE_WIDTH;

   logic [COORD_WIDTH-1:0] cursor_x_ff, cursor_x_in;
   logic [COORD_WIDTH-1:0] cursor_y_ff, cursor_y_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic signed [SW-1:0]   sum_x;
   logic signed [SW-1:0]   sum_y;

   function automatic logic [COORD_WIDTH-1:0] clamp_coord(
      input logic signed [SW-1:0]   v,
      input logic [COORD_WIDTH-1:0] hi
   );
      logic [COORD_WIDTH-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({2'b00, hi})) begin
         res = hi;
      end else begin
         res = v[COORD_WIDTH-1:0];
      end
      return res;
   endfunction

   // X adds the delta, Y subtracts it (screen Y grows downward)
   assign sum_x = $signed({2'b00, cursor_x_ff})
                + $signed({{PAD{packet.move_x[7]}}, packet.move_x});
   assign sum_y = $signed({2'b00, cursor_y_ff})
                - $signed({{PAD{packet.move_y[7]}}, packet.move_y});

   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      count_in    = count_ff;
      if (packet.complete) begin
         cursor_x_in = clamp_coord(sum_x, coord_max);
         cursor_y_in = clamp_coord(sum_y, coord_max);
         count_in    = count_ff + COUNT_WIDTH'(1);
      end
   end

   assign cursor_x_next = cursor_x_in;
   assign cursor_y_next = cursor_y_in;
   assign count_next    = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         count_ff    <= '0;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         count_ff    <= count_in;
      end
   end

endmodule

// ===== hw/rtl/ps2_mouse_packet_tracker.sv =====
`timescale 1ns / 1ps
// The result word is valid in the cycle after a packet's third byte is taken; framing, cursor
// add and clamp fit between two registers. Throughput: one byte per cycle unless stalled.
// req_stall rises only when a packet-closing byte meets a result word still held by rsp_stall.
// Reset (synchronous, active high): reporting off, coord_max 4095, cursor and count zero,
// framing back at the header byte, no result pending.
module ps2_mouse_packet_tracker #(
   parameter int COORD_WIDTH = ps2mt_pkg::COORD_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = ps2mt_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // control registers
   input  logic                                    csr_write_enable,
   input  logic [ps2mt_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ps2mt_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   // byte input
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [ps2mt_pkg::BYTE_WIDTH-1:0]        req_data_byte,
   // packet result
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [COORD_WIDTH-1:0]                  rsp_cursor_x_pos,
   output logic [COORD_WIDTH-1:0]                  rsp_cursor_y_pos,
   output logic [ps2mt_pkg::BUTTON_WIDTH-1:0]      rsp_buttons,
   output logic signed [ps2mt_pkg::BYTE_WIDTH-1:0] rsp_move_x,
   output logic signed [ps2mt_pkg::BYTE_WIDTH-1:0] rsp_move_y,
   output logic [COUNT_WIDTH-1:0]                  rsp_packets_seen
);

   logic                   enable_ff;
   logic [COORD_WIDTH-1:0] coord_max_ff;
   logic                   byte_take;
   logic                   last_pending;
   ps2mt_pkg::packet_type  packet;
   logic [COORD_WIDTH-1:0] cursor_x_next;
   logic [COORD_WIDTH-1:0] cursor_y_next;
   logic [COUNT_WIDTH-1:0] count_next;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [COORD_WIDTH-1:0]               x_pos_ff;
   logic [COORD_WIDTH-1:0]               y_pos_ff;
   logic [ps2mt_pkg::BUTTON_WIDTH-1:0]   buttons_ff;
   logic [ps2mt_pkg::BYTE_WIDTH-1:0]     move_x_ff;
   logic [ps2mt_pkg::BYTE_WIDTH-1:0]     move_y_ff;
   logic [COUNT_WIDTH-1:0]               count_ff;

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         coord_max_ff <= COORD_WIDTH'(ps2mt_pkg::COORD_MAX_RESET);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ps2mt_pkg::CSR_REPORTING_ENABLE: enable_ff    <= csr_write_data[0];
            ps2mt_pkg::CSR_COORD_MAX:        coord_max_ff <= COORD_WIDTH'(csr_write_data);
            default: ;
         endcase
      end
   end

   // hold off only the byte that would overwrite a result still waiting
   assign req_stall = rsp_valid_ff & rsp_stall & enable_ff & last_pending;
   // bytes taken while reporting is off are dropped
   assign byte_take = req_valid & ~req_stall & enable_ff;

   ps2mt_framer u_framer (
      .clock        (clock),
      .reset        (reset),
      .byte_take    (byte_take),
      .data_byte    (req_data_byte),
      .last_pending (last_pending),
      .packet       (packet)
   );

   ps2mt_cursor #(
      .COORD_WIDTH (COORD_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_cursor (
      .clock         (clock),
      .reset         (reset),
      .packet        (packet),
      .coord_max     (coord_max_ff),
      .cursor_x_next (cursor_x_next),
      .cursor_y_next (cursor_y_next),
      .count_next    (count_next)
   );

   // result word valid
   always_comb begin
      priority if (packet.complete) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only with a new packet
   always_ff @(posedge clock) begin
      if (packet.complete) begin
         x_pos_ff   <= cursor_x_next;
         y_pos_ff   <= cursor_y_next;
         buttons_ff <= packet.buttons;
         move_x_ff  <= packet.move_x;
         move_y_ff  <= packet.move_y;
         count_ff   <= count_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_x_pos = x_pos_ff;
   assign rsp_cursor_y_pos = y_pos_ff;
   assign rsp_buttons      = buttons_ff;
   assign rsp_move_x       = $signed(move_x_ff);
   assign rsp_move_y       = $signed(move_y_ff);
   assign rsp_packets_seen = count_ff;

endmodule

// ===== hw/rtl/ps2mt_checker.sv =====
`timescale 1ns / 1ps
`include "ps2_mouse_packet_tracker_macros.svh"
module ps2mt_checker #(
   parameter int COORD_WIDTH = ps2mt_pkg::COORD_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = ps2mt_pkg::COUNT_WIDTH_DEFAULT
) (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic [COORD_WIDTH-1:0]                  rsp_cursor_x_pos,
   input logic [COORD_WIDTH-1:0]                  rsp_cursor_y_pos,
   input logic [ps2mt_pkg::BUTTON_WIDTH-1:0]      rsp_buttons,
   input logic signed [ps2mt_pkg::BYTE_WIDTH-1:0] rsp_move_x,
   input logic signed [ps2mt_pkg::BYTE_WIDTH-1:0] rsp_move_y,
   input logic [COUNT_WIDTH-1:0]                  rsp_packets_seen
);

   localparam int WORD_WIDTH = 2 * COORD_WIDTH + ps2mt_pkg::BUTTON_WIDTH
                             + 2 * ps2mt_pkg::BYTE_WIDTH + COUNT_WIDTH;

   logic [WORD_WIDTH-1:0] rsp_word;

   // whole result payload as one vector
   assign rsp_word = {rsp_cursor_x_pos, rsp_cursor_y_pos, rsp_buttons,
                      rsp_move_x, rsp_move_y, rsp_packets_seen};

   // a held result word keeps its value
   `PS2MT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                      rsp_valid && $stable(rsp_word))

   // input backs up only behind a held result
   `PS2MT_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // a new result word follows a taken byte
   `PS2MT_ASSERT_IMPL(a_rsp_from_byte, clock, reset, $rose(rsp_valid),
                      $past(req_valid && !req_stall))

   // back-to-back words count up by one
   `PS2MT_ASSERT_IMPL(a_count_step, clock, reset,
                      (rsp_valid && !rsp_stall) ##1
                      (rsp_valid && (rsp_packets_seen != $past(rsp_packets_seen))),
                      rsp_packets_seen == ($past(rsp_packets_seen) + COUNT_WIDTH'(1)))

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker #(
   .COORD_WIDTH (COORD_WIDTH),
   .COUNT_WIDTH (COUNT_WIDTH)
) u_checker (.*);
